// ===== rtl/uv_sphere_vertex_generator_assert.svh =====
// Assertion macros for the UV sphere vertex generator.
// Needs nothing else; include by bare file name.
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UVS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define UVS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/uvs_pkg.sv =====
// Shared constants and types for the UV sphere vertex generator.
// No dependencies.
`timescale 1ns / 1ps

package uvs_pkg;

  localparam int DEF_MAX_SMOOTHNESS = 31;
  localparam int DEF_TRIG_FRAC_BITS = 15;

  localparam int SMOOTH_W = 5;
  localparam int RADIUS_W = 16;
  localparam int CFG_W    = 16;
  localparam int POS_W    = 17;
  localparam int Q15_W    = 16;
  localparam int TEX_W    = 17;

  // Iterative divider sizes: dividends stay below 2^38, divisors below 512.
  localparam int DIV_W = 40;
  localparam int DVS_W = 9;

  localparam int          SERIES_TERMS = 11;
  localparam logic [31:0] PI_HALF_Q30  = 32'd1686629713;
  localparam logic [31:0] Q30_ONE      = 32'd1073741824;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_SMOOTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
  } tex_t;

endpackage

// ===== rtl/uvs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on uvs_pkg for operand widths.
`timescale 1ns / 1ps

module uvs_div import uvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] quot_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quot_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(DIV_W - 1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], fits};
      rem_q  <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/uvs_trig.sv =====
// Table fill engine: sine, cosine and uv of one step index k of n.
// Depends on uvs_pkg and uvs_div.
`timescale 1ns / 1ps

module uvs_trig import uvs_pkg::*; #(
  parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS,
  parameter int IW             = 6,
  parameter int NW             = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [IW-1:0]              k_i,
  input  logic [NW-1:0]              n_i,
  output logic                       done_o,
  output logic signed [TRIG_FRAC_BITS:0] sn_o,
  output logic signed [TRIG_FRAC_BITS:0] cs_o,
  output tex_t                       tex_o
);

  localparam int TW     = TRIG_FRAC_BITS + 1;
  localparam int RS     = 30 - TRIG_FRAC_BITS;
  localparam int SACC_W = 35;
  localparam logic [SACC_W-1:0] LIM = SACC_W'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

  typedef enum logic [3:0] {
    T_IDLE, T_QDIV, T_XDIV, T_SQ, T_SDIV, T_CDIV, T_TUDIV, T_TVDIV, T_FIN
  } trig_state_e;

  trig_state_e state_q;
  logic              issued_q, done_q;
  logic [IW-1:0]     k_q;
  logic [NW-1:0]     n_q, f_q;
  logic [1:0]        q_q;
  logic [31:0]       x_q, x2_q, ts_q, tc_q;
  logic signed [SACC_W-1:0] ss_q, cc_q;
  logic [3:0]        m_q;
  logic [TEX_W-1:0]  tu_q, tv_q;
  logic signed [TW-1:0] sn_q, cs_q;

  logic             div_start, div_done, is_div;
  logic [DIV_W-1:0] dividend, div_quot;
  logic [DVS_W-1:0] divisor, div_rem;
  logic [63:0]      sq, mul_s, mul_c;
  logic signed [SACC_W-1:0] quot_ext;
  logic [TRIG_FRAC_BITS-1:0] s1, c1;

  function automatic logic [DVS_W-1:0] sin_den(input logic [3:0] m);
    sin_den = DVS_W'({m, 1'b0}) * DVS_W'({m, 1'b1});
  endfunction

  function automatic logic [DVS_W-1:0] cos_den(input logic [3:0] m);
    cos_den = (DVS_W'({m, 1'b0}) - DVS_W'(1)) * DVS_W'({m, 1'b0});
  endfunction

  // Drop negatives, round half up to the trig format, saturate below one.
  function automatic logic [TRIG_FRAC_BITS-1:0] to_trig(input logic signed [SACC_W-1:0] v);
    logic [SACC_W-1:0] a, t;
    a = v[SACC_W-1] ? '0 : $unsigned(v);
    t = (a + (SACC_W'(1) << (RS - 1))) >> RS;
    if (t > LIM) t = LIM;
    to_trig = t[TRIG_FRAC_BITS-1:0];
  endfunction

  assign sq    = 64'(x_q) * 64'(x_q);
  assign mul_s = 64'(ts_q) * 64'(x2_q);
  assign mul_c = 64'(tc_q) * 64'(x2_q);
  assign quot_ext = $signed(SACC_W'(div_quot[31:0]));
  assign s1 = to_trig(ss_q);
  assign c1 = to_trig(cc_q);

  always_comb begin
    dividend = '0;
    divisor  = '0;
    is_div   = 1'b1;
    case (state_q)
      T_QDIV: begin
        dividend = DIV_W'({k_q, 2'b00});
        divisor  = DVS_W'(n_q);
      end
      T_XDIV: begin
        dividend = DIV_W'(f_q) * DIV_W'(PI_HALF_Q30) + DIV_W'(n_q >> 1);
        divisor  = DVS_W'(n_q);
      end
      T_SDIV: begin
        dividend = DIV_W'(mul_s[63:30]);
        divisor  = sin_den(m_q);
      end
      T_CDIV: begin
        dividend = DIV_W'(mul_c[63:30]);
        divisor  = cos_den(m_q);
      end
      T_TUDIV: begin
        dividend = (DIV_W'(k_q) << 16) + DIV_W'(n_q >> 1);
        divisor  = DVS_W'(n_q);
      end
      T_TVDIV: begin
        dividend = (DIV_W'(k_q) << 16) + DIV_W'(n_q >> 2);
        divisor  = DVS_W'(n_q >> 1);
      end
      default: is_div = 1'b0;
    endcase
  end

  assign div_start = is_div && !issued_q;

  uvs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      issued_q <= 1'b0;
      done_q   <= 1'b0;
      k_q      <= '0;
      n_q      <= '0;
      f_q      <= '0;
      q_q      <= '0;
      x_q      <= '0;
      x2_q     <= '0;
      ts_q     <= '0;
      tc_q     <= '0;
      ss_q     <= '0;
      cc_q     <= '0;
      m_q      <= '0;
      tu_q     <= '0;
      tv_q     <= '0;
      sn_q     <= '0;
      cs_q     <= '0;
    end else begin
      done_q <= (state_q == T_FIN);
      if (div_start) issued_q <= 1'b1;
      if (div_done)  issued_q <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (start_i) begin
            k_q     <= k_i;
            n_q     <= n_i;
            state_q <= T_QDIV;
          end
        end
        T_QDIV: begin
          if (div_done) begin
            q_q     <= div_quot[1:0];
            f_q     <= NW'(div_rem);
            state_q <= T_XDIV;
          end
        end
        T_XDIV: begin
          if (div_done) begin
            x_q     <= div_quot[31:0];
            state_q <= T_SQ;
          end
        end
        T_SQ: begin
          x2_q    <= sq[61:30];
          ts_q    <= x_q;
          tc_q    <= Q30_ONE;
          ss_q    <= $signed(SACC_W'(x_q));
          cc_q    <= $signed(SACC_W'(Q30_ONE));
          m_q     <= 4'd1;
          state_q <= T_SDIV;
        end
        T_SDIV: begin
          if (div_done) begin
            ts_q    <= div_quot[31:0];
            ss_q    <= m_q[0] ? ss_q - quot_ext : ss_q + quot_ext;
            state_q <= T_CDIV;
          end
        end
        T_CDIV: begin
          if (div_done) begin
            tc_q <= div_quot[31:0];
            cc_q <= m_q[0] ? cc_q - quot_ext : cc_q + quot_ext;
            if (m_q == 4'(SERIES_TERMS)) begin
              state_q <= T_TUDIV;
            end else begin
              m_q     <= m_q + 4'd1;
              state_q <= T_SDIV;
            end
          end
        end
        T_TUDIV: begin
          if (div_done) begin
            tu_q    <= div_quot[TEX_W-1:0];
            state_q <= T_TVDIV;
          end
        end
        T_TVDIV: begin
          if (div_done) begin
            tv_q    <= div_quot[TEX_W-1:0];
            state_q <= T_FIN;
          end
        end
        T_FIN: begin
          // Fold the first-quadrant pair into the quadrant of k.
          case (q_q)
            2'd0: begin sn_q <= $signed({1'b0, s1});  cs_q <= $signed({1'b0, c1});  end
            2'd1: begin sn_q <= $signed({1'b0, c1});  cs_q <= -$signed({1'b0, s1}); end
            2'd2: begin sn_q <= -$signed({1'b0, s1}); cs_q <= -$signed({1'b0, c1}); end
            default: begin sn_q <= -$signed({1'b0, c1}); cs_q <= $signed({1'b0, s1}); end
          endcase
          state_q <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign sn_o     = sn_q;
  assign cs_o     = cs_q;
  assign tex_o.tu = tu_q;
  assign tex_o.tv = tv_q;

endmodule

// ===== rtl/uvs_cache.sv =====
// Step table memory: one write port, two registered read ports, valid bits.
// Depends on uvs_pkg for its default parameter sizes.
`timescale 1ns / 1ps

module uvs_cache import uvs_pkg::*; #(
  parameter int EW    = 2 * (DEF_TRIG_FRAC_BITS + 1) + 2 * TEX_W,
  parameter int DEPTH = 2 * (DEF_MAX_SMOOTHNESS + 1),
  parameter int IW    = $clog2(2 * (DEF_MAX_SMOOTHNESS + 1))
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          we_i,
  input  logic [IW-1:0] wa_i,
  input  logic [EW-1:0] wd_i,
  input  logic [IW-1:0] ra_a_i,
  input  logic [IW-1:0] ra_b_i,
  output logic [EW-1:0] rd_a_o,
  output logic [EW-1:0] rd_b_o,
  output logic          vld_a_o,
  output logic          vld_b_o
);

  logic [EW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [EW-1:0] rd_a_q, rd_b_q;
  logic vld_a_q, vld_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[wa_i] <= wd_i;
    rd_a_q <= mem_q[ra_a_i];
    rd_b_q <= mem_q[ra_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (clr_i) vld_q <= '0;
      else if (we_i) vld_q[wa_i] <= 1'b1;
      vld_a_q <= vld_q[ra_a_i] && !clr_i;
      vld_b_q <= vld_q[ra_b_i] && !clr_i;
    end
  end

  assign rd_a_o  = rd_a_q;
  assign rd_b_o  = rd_b_q;
  assign vld_a_o = vld_a_q;
  assign vld_b_o = vld_b_q;

endmodule

// ===== rtl/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex generator: config, quad sequencer, vertex math.
// Depends on uvs_pkg, uvs_cache, uvs_trig and the assertion macro header.
`timescale 1ns / 1ps
// Usage:
//   Each transfer on the input channel (in_valid_i/in_ready_o) asks for the next quad of a
//   latitude-longitude sphere; the block answers with six vertex transfers on
//   the output channel, last_of_quad_o high on the sixth and mesh_done_o on the
//   sixth of the final quad. restart_i = 1 jumps back to the first quad.
//   radius and smoothness are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while no item is in flight.
//   Sine, cosine and uv for each step index live in a small memory filled on
//   demand by an iterative series engine. On a hit each vertex passes through
//   the steps read, check, U0, U2, P0, P1 and emit; the next item is taken
//   once the quad's last vertex has been emitted. A miss runs the engine
//   (26 serial divisions) and at most two misses occur per vertex; after
//   one pass over the mesh every lookup hits.
//   Reset and each smoothness write clear the table's valid bits at once: no
//   sweep, the block is ready the cycle after reset.
//   Results sit in an output register; if the receiver stalls, the sequencer
//   holds at the emit step and resumes when the register is taken. The next
//   item is accepted while the final vertex still waits there.

module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int MAX_SMOOTHNESS = DEF_MAX_SMOOTHNESS,
  parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    restart_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o,
  output logic signed [POS_W-1:0] pos_z_o,
  output logic signed [Q15_W-1:0] norm_x_o,
  output logic signed [Q15_W-1:0] norm_y_o,
  output logic signed [Q15_W-1:0] norm_z_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic signed [Q15_W-1:0] blue_o,
  output logic                    last_of_quad_o,
  output logic                    mesh_done_o
);

  `include "uv_sphere_vertex_generator_assert.svh"

  // Smoothness register is five bits wide, so it never exceeds 31.
  localparam int SMAX  = (MAX_SMOOTHNESS < 31) ? MAX_SMOOTHNESS : 31;
  localparam int DEPTH = 2 * (SMAX + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(SMAX + 2);
  localparam int T     = TRIG_FRAC_BITS;
  localparam int TW    = T + 1;
  localparam int EW    = 2 * TW + 2 * TEX_W;
  localparam int PW    = (2 * T + 3 > T + 20) ? 2 * T + 3 : T + 20;
  localparam int XW    = 8;
  localparam int DN_SH = (T > 15) ? T - 15 : 0;
  localparam int UP_SH = (T < 15) ? 15 - T : 0;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_FILL, S_U0, S_U2, S_P0, S_P1, S_EMIT
  } seq_state_e;

  // Sign-magnitude rounding, halves away from zero.
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int sh);
    logic [PW-1:0] m;
    logic neg;
    neg = v[PW-1];
    m   = neg ? $unsigned(-v) : $unsigned(v);
    if (sh > 0) m = (m + (PW'(1) << (sh - 1))) >> sh;
    rnd = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [TW-1:0] v);
    logic signed [PW-1:0] r;
    r = rnd(PW'(v), DN_SH) <<< UP_SH;
    if (r > PW'(32767)) r = PW'(32767);
    if (r < -PW'(32767)) r = -PW'(32767);
    to_q15 = r[Q15_W-1:0];
  endfunction

  // Corner offsets of the six vertices of a quad, in winding order.
  function automatic logic vtx_dr(input logic [2:0] v);
    unique case (v)
      3'd2, 3'd4, 3'd5: vtx_dr = 1'b1;
      default:          vtx_dr = 1'b0;
    endcase
  endfunction

  function automatic logic vtx_dc(input logic [2:0] v);
    unique case (v)
      3'd1, 3'd3, 3'd4: vtx_dc = 1'b1;
      default:          vtx_dc = 1'b0;
    endcase
  endfunction

  seq_state_e state_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [SMOOTH_W-1:0] smooth_q;
  logic [RW-1:0]       ring_q;
  logic [NW-1:0]       slice_q;
  logic [2:0]          v_q;
  logic                done_q;
  logic [IW-1:0]       fill_k_q;
  logic signed [TW-1:0] si_q, ci_q, sj_q, cj_q, u0_q, u2_q;
  logic [TEX_W-1:0]    tu_q, tv_q;
  logic signed [POS_W-1:0] px_q, py_q;

  logic                out_valid_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [Q15_W-1:0] norm_x_q, norm_y_q, norm_z_q, blue_q;
  logic [TEX_W-1:0]    tex_u_q, tex_v_q;
  logic                last_q, mesh_q;

  logic [SMOOTH_W-1:0] s_eff;
  logic [5:0]          s1;
  logic [NW-1:0]       n;
  logic [RW-1:0]       vi;
  logic [NW-1:0]       vj;
  logic [IW-1:0]       ki, kj;
  logic                in_xfer, slot_free, miss_a, miss_b;
  logic                restart_now;
  logic [RW-1:0]       ring0;
  logic [NW-1:0]       slice0;
  logic [RW-1:0]       ring_nx;
  logic [NW-1:0]       slice_nx;
  logic signed [PW-1:0] u0_r, u2_r, px_r, py_r, pz_r;

  logic [EW-1:0] rd_a, rd_b, wd;
  logic          vld_a, vld_b, cache_we, cache_clr;
  logic          trig_start, trig_done;
  logic signed [TW-1:0] trig_sn, trig_cs;
  tex_t          trig_tex, tex_a, tex_b;
  logic signed [TW-1:0] a_sn, a_cs, b_sn, b_cs;
  logic signed [PW-1:0] rad_ext;

  assign s_eff = (smooth_q > SMOOTH_W'(SMAX)) ? SMOOTH_W'(SMAX) : smooth_q;
  assign s1    = {1'b0, s_eff} + 6'd1;
  assign n     = NW'({s1, 1'b0});

  // Vertex grid coordinates and their table indexes; index n folds to 0.
  assign vi = ring_q + RW'(vtx_dr(v_q));
  assign vj = slice_q + NW'(vtx_dc(v_q));
  assign ki = IW'(vi);
  assign kj = (vj == n) ? '0 : IW'(vj);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Start over when asked or when a smaller mesh left the counters outside.
  assign restart_now = restart_i || (XW'(ring_q) > XW'(s_eff)) || (slice_q >= n);
  assign ring0  = restart_now ? '0 : ring_q;
  assign slice0 = restart_now ? '0 : slice_q;

  assign slice_nx = slice_q + NW'(1);
  assign ring_nx  = ring_q + RW'(1);

  assign miss_a     = (state_q == S_CHK) && !vld_a;
  assign miss_b     = (state_q == S_CHK) && vld_a && !vld_b;
  assign trig_start = miss_a || miss_b;
  assign cache_we   = (state_q == S_FILL) && trig_done;
  assign cache_clr  = cfg_we_i && (cfg_idx_i == REG_SMOOTH);
  assign wd         = {trig_sn, trig_cs, trig_tex};

  assign {a_sn, a_cs, tex_a} = rd_a;
  assign {b_sn, b_cs, tex_b} = rd_b;
  assign rad_ext = PW'($signed({1'b0, radius_q}));

  // Rounded products of the vertex math, one used per sequencer step.
  assign u0_r = rnd(PW'(cj_q) * PW'(si_q), T);
  assign u2_r = rnd(PW'(sj_q) * PW'(si_q), T);
  assign px_r = rnd(rad_ext * PW'(u0_q), T);
  assign py_r = rnd(rad_ext * PW'(ci_q), T);
  assign pz_r = rnd(rad_ext * PW'(u2_q), T);

  uvs_cache #(
    .EW    (EW),
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_cache (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cache_clr),
    .we_i    (cache_we),
    .wa_i    (fill_k_q),
    .wd_i    (wd),
    .ra_a_i  (ki),
    .ra_b_i  (kj),
    .rd_a_o  (rd_a),
    .rd_b_o  (rd_b),
    .vld_a_o (vld_a),
    .vld_b_o (vld_b)
  );

  uvs_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .IW             (IW),
    .NW             (NW)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .k_i     (miss_a ? ki : kj),
    .n_i     (n),
    .done_o  (trig_done),
    .sn_o    (trig_sn),
    .cs_o    (trig_cs),
    .tex_o   (trig_tex)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_W'(256);
      smooth_q <= SMOOTH_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        REG_SMOOTH: smooth_q <= cfg_data_i[SMOOTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Quad sequencer: read the table, fill on a miss, then the vertex math and the emit step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ring_q   <= '0;
      slice_q  <= '0;
      v_q      <= '0;
      done_q   <= 1'b0;
      fill_k_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop valid once taken, unless the emit step refills the register.
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            ring_q  <= ring0;
            slice_q <= slice0;
            done_q  <= (XW'(ring0) == XW'(s_eff)) && (slice0 == n - NW'(1));
            v_q     <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (trig_start) begin
            fill_k_q <= miss_a ? ki : kj;
            state_q  <= S_FILL;
          end else begin
            state_q <= S_U0;
          end
        end
        S_FILL: if (trig_done) state_q <= S_RD;
        S_U0:   state_q <= S_U2;
        S_U2:   state_q <= S_P0;
        S_P0:   state_q <= S_P1;
        S_P1:   state_q <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            if (v_q == 3'd5) begin
              // Advance to the next quad, wrapping after the last one.
              if (slice_nx >= n) begin
                slice_q <= '0;
                ring_q  <= (XW'(ring_nx) > XW'(s_eff)) ? '0 : ring_nx;
              end else begin
                slice_q <= slice_nx;
              end
              state_q <= S_IDLE;
            end else begin
              v_q     <= v_q + 3'd1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHK) begin
      si_q <= a_sn;
      ci_q <= a_cs;
      tv_q <= tex_a.tv;
      sj_q <= b_sn;
      cj_q <= b_cs;
      tu_q <= (vj == n) ? TEX_W'(65536) : tex_b.tu;
    end
    if (state_q == S_U0) u0_q <= u0_r[TW-1:0];
    if (state_q == S_U2) u2_q <= u2_r[TW-1:0];
    if (state_q == S_P0) px_q <= px_r[POS_W-1:0];
    if (state_q == S_P1) py_q <= py_r[POS_W-1:0];
    if (state_q == S_EMIT && slot_free) begin
      pos_x_q  <= px_q;
      pos_y_q  <= py_q;
      pos_z_q  <= pz_r[POS_W-1:0];
      norm_x_q <= to_q15(u0_q);
      norm_y_q <= to_q15(ci_q);
      norm_z_q <= to_q15(u2_q);
      tex_u_q  <= tu_q;
      tex_v_q  <= tv_q;
      blue_q   <= to_q15(sj_q);
      last_q   <= (v_q == 3'd5);
      mesh_q   <= done_q && (v_q == 3'd5);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign pos_z_o        = pos_z_q;
  assign norm_x_o       = norm_x_q;
  assign norm_y_o       = norm_y_q;
  assign norm_z_o       = norm_z_q;
  assign tex_u_o        = tex_u_q;
  assign tex_v_o        = tex_v_q;
  assign blue_o         = blue_q;
  assign last_of_quad_o = last_q;
  assign mesh_done_o    = mesh_q;

  `UVS_ASSERT_IMP(a_done_on_last, clk_i, rst_ni, out_valid_o && mesh_done_o, last_of_quad_o)
  `UVS_ASSERT_NXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, !in_ready_o)
  `UVS_ASSERT_IMP(a_index_in_range, clk_i, rst_ni, state_q == S_CHK, (XW'(ki) < XW'(n)) && (XW'(kj) < XW'(n)))
  `UVS_ASSERT_IMP(a_write_only_fill, clk_i, rst_ni, cache_we, !cache_clr && (state_q == S_FILL))

endmodule

// ===== tb/uv_sphere_vertex_generator_tb.sv =====
// Self-checking testbench for the UV sphere vertex generator.
// Depends on uvs_pkg and the uv_sphere_vertex_generator top level.
`timescale 1ns / 1ps

// One vertex as it leaves the block.
typedef struct {
  logic signed [uvs_pkg::POS_W-1:0] px, py, pz;
  logic signed [uvs_pkg::Q15_W-1:0] nx, ny, nz;
  logic [uvs_pkg::TEX_W-1:0]        tu, tv;
  logic signed [uvs_pkg::Q15_W-1:0] blue;
  logic                             lastq, done;
} vertex_t;

// Sphere mesh predictor and queue of expected vertices.
class sphere_scoreboard;
  localparam int TB = uvs_pkg::DEF_TRIG_FRAC_BITS;

  int unsigned radius = 256;
  int unsigned smooth = 8;
  int unsigned ring   = 0;
  int unsigned slice  = 0;
  int          errors = 0;
  vertex_t     expected_verts[$];

  function longint rnd_shift(longint v, int sh);
    longint unsigned m;
    bit neg;
    neg = v < 0;
    m = neg ? -v : v;
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // sin and cos of k/n of a full turn at TB fraction bits
  function void sin_cos(int unsigned k, int unsigned n, output longint sn, output longint cs);
    longint unsigned r, q, f, x, x2, ts, tc;
    longint ss, cc, s1, c1, lim;
    lim = (64'd1 << TB) - 1;
    r = (longint'(k) * 4) % (longint'(n) * 4);
    q = r / n;
    f = r % n;
    x = (f * 64'd1686629713 + n / 2) / n;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1073741824;
    ss = x;
    cc = 64'd1073741824;
    for (int m = 1; m <= uvs_pkg::SERIES_TERMS; m++) begin
      ts = ((ts * x2) >> 30) / longint'((2 * m) * (2 * m + 1));
      tc = ((tc * x2) >> 30) / longint'((2 * m - 1) * (2 * m));
      if (m % 2) begin ss -= ts; cc -= tc; end
      else begin ss += ts; cc += tc; end
    end
    if (ss < 0) ss = 0;
    if (cc < 0) cc = 0;
    s1 = clamp(rnd_shift(ss, 30 - TB), lim);
    c1 = clamp(rnd_shift(cc, 30 - TB), lim);
    case (q % 4)
      0: begin sn = s1;  cs = c1;  end
      1: begin sn = c1;  cs = -s1; end
      2: begin sn = -s1; cs = -c1; end
      default: begin sn = -c1; cs = s1; end
    endcase
  endfunction

  function longint q15(longint v);
    return clamp(rnd_shift(v, TB - 15), 32767);
  endfunction

  function vertex_t vertex_at(int unsigned i, int unsigned j, int unsigned s, bit lq, bit dn);
    vertex_t vx;
    int unsigned n;
    longint si, ci, sj, cj, ux, uy, uz;
    n = 2 * (s + 1);
    sin_cos(i, n, si, ci);
    sin_cos(j, n, sj, cj);
    ux = rnd_shift(cj * si, TB);
    uy = ci;
    uz = rnd_shift(sj * si, TB);
    vx.px = uvs_pkg::POS_W'(rnd_shift(longint'(radius) * ux, TB));
    vx.py = uvs_pkg::POS_W'(rnd_shift(longint'(radius) * uy, TB));
    vx.pz = uvs_pkg::POS_W'(rnd_shift(longint'(radius) * uz, TB));
    vx.nx = uvs_pkg::Q15_W'(q15(ux));
    vx.ny = uvs_pkg::Q15_W'(q15(uy));
    vx.nz = uvs_pkg::Q15_W'(q15(uz));
    vx.tu = uvs_pkg::TEX_W'((longint'(j) * 65536 + n / 2) / n);
    vx.tv = uvs_pkg::TEX_W'((longint'(i) * 65536 + (s + 1) / 2) / (s + 1));
    vx.blue = uvs_pkg::Q15_W'(q15(sj));
    vx.lastq = lq;
    vx.done = dn;
    return vx;
  endfunction

  // Predict the six vertices of the next quad.
  function void note_item(bit restart);
    int unsigned s, cols;
    bit dn;
    bit [5:0] dr = 6'b110100; // bit v: row offset of vertex v
    bit [5:0] dc = 6'b011010;
    s = (smooth > 31) ? 31 : smooth;
    cols = 2 * s + 2;
    if (restart || ring > s || slice >= cols) begin
      ring = 0;
      slice = 0;
    end
    dn = (ring == s) && (slice == cols - 1);
    for (int v = 0; v < 6; v++)
      expected_verts.push_back(vertex_at(ring + dr[v], slice + dc[v], s, v == 5, dn && v == 5));
    slice++;
    if (slice >= cols) begin
      slice = 0;
      ring++;
      if (ring > s) ring = 0;
    end
  endfunction

  function void cmp(string f, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", f, e, a);
      errors++;
    end
  endfunction

  function void check_result(vertex_t a);
    vertex_t e;
    if (expected_verts.size() == 0) begin
      $error("vertex transfer with nothing expected");
      errors++;
      return;
    end
    e = expected_verts.pop_front();
    cmp("pos_x", e.px, a.px);
    cmp("pos_y", e.py, a.py);
    cmp("pos_z", e.pz, a.pz);
    cmp("norm_x", e.nx, a.nx);
    cmp("norm_y", e.ny, a.ny);
    cmp("norm_z", e.nz, a.nz);
    cmp("tex_u", e.tu, a.tu);
    cmp("tex_v", e.tv, a.tv);
    cmp("blue", e.blue, a.blue);
    cmp("last_of_quad", e.lastq, a.lastq);
    cmp("mesh_done", e.done, a.done);
  endfunction
endclass

module uv_sphere_vertex_generator_tb;
  import uvs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 260;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  cfg_reg_e                cfg_idx_i = REG_RADIUS;
  logic [CFG_W-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    restart_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [Q15_W-1:0] norm_x_o, norm_y_o, norm_z_o, blue_o;
  logic [TEX_W-1:0]        tex_u_o, tex_v_o;
  logic                    last_of_quad_o, mesh_done_o;

  sphere_scoreboard sb = new();
  bit quiet = 1'b0;     // no idling on either side while set
  int idle_cycles = 0;  // cycles since the last transfer on any channel

  uv_sphere_vertex_generator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .restart_i,
    .out_valid_o, .out_ready_i,
    .pos_x_o, .pos_y_o, .pos_z_o, .norm_x_o, .norm_y_o, .norm_z_o,
    .tex_u_o, .tex_v_o, .blue_o, .last_of_quad_o, .mesh_done_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // Receiver: hold ready for a run of cycles, then drop it for a gap.
  initial begin
    int g;
    @(negedge clk_i);
    forever begin
      out_ready_i = 1'b1;
      repeat (1 + $urandom_range(0, 6)) @(negedge clk_i);
      if (!quiet) begin
        g = pick_gap();
        if (g > 0) begin
          out_ready_i = 1'b0;
          repeat (g) @(negedge clk_i);
        end
      end
    end
  end

  // Check every vertex transfer against the oldest expectation.
  always @(posedge clk_i) begin
    vertex_t act;
    if (out_valid_o && out_ready_i) begin
      act.px = pos_x_o;   act.py = pos_y_o;   act.pz = pos_z_o;
      act.nx = norm_x_o;  act.ny = norm_y_o;  act.nz = norm_z_o;
      act.tu = tex_u_o;   act.tv = tex_v_o;   act.blue = blue_o;
      act.lastq = last_of_quad_o;
      act.done = mesh_done_o;
      sb.check_result(act);
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one quad request and hold it until the transfer.
  task automatic send_quad(bit restart);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    restart_i = restart;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(restart);
  endtask

  // Drop valid for a gap after a transfer; a zero gap keeps it high.
  task automatic sender_gap(int g);
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // Hold off until every expected vertex has arrived.
  task automatic drain();
    sender_gap(1);
    while (sb.expected_verts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_RADIUS) sb.radius = val & 16'hFFFF;
    else sb.smooth = val & 5'h1F;
  endtask

  task automatic run_burst(int unsigned count, bit restart_first);
    for (int k = 0; k < count; k++) begin
      send_quad(k == 0 && restart_first);
      sender_gap(quiet ? 0 : pick_gap());
    end
  endtask

  initial begin
    int sent;
    int unsigned rad, sm, cnt;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, restart in mid-mesh.
    quiet = 1'b1;
    send_quad(1'b1);
    send_quad(1'b0);
    send_quad(1'b0);
    send_quad(1'b1);
    send_quad(1'b0);
    drain();
    // Smallest mesh, full radius: wrap and mesh_done every second quad.
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_SMOOTH, 0);
    quiet = 1'b0;
    run_burst(5, 1'b0);
    drain();
    // Zero radius: positions vanish, normals stay.
    write_reg(REG_RADIUS, 0);
    run_burst(3, 1'b0);
    drain();
    // Largest mesh, smallest nonzero radius.
    write_reg(REG_RADIUS, 1);
    write_reg(REG_SMOOTH, 31);
    run_burst(3, 1'b1);
    drain();
    // Advance past the first row, then shrink the mesh under the counters.
    write_reg(REG_RADIUS, 300);
    write_reg(REG_SMOOTH, 2);
    run_burst(7, 1'b1);
    drain();
    write_reg(REG_SMOOTH, 0);
    run_burst(2, 1'b0);
    drain();

    // Random phases: mostly small meshes walked in order, restarts as noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: rad = 16'hFFFF;
        1: rad = $urandom_range(0, 3);
        default: rad = $urandom_range(0, 16'hFFFF);
      endcase
      case ($urandom_range(0, 9))
        0: sm = 31;
        1, 2: sm = $urandom_range(5, 12);
        default: sm = $urandom_range(0, 4);
      endcase
      write_reg(REG_RADIUS, rad);
      write_reg(REG_SMOOTH, sm);
      quiet = ($urandom_range(0, 3) == 0);
      cnt = $urandom_range(20, 50);
      for (int k = 0; k < cnt; k++) begin
        send_quad($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 29) == 0) drain();
        else sender_gap(quiet ? 0 : pick_gap());
      end
      sent += cnt;
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_verts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/uvs_pkg.sv
rtl/uvs_div.sv
rtl/uvs_trig.sv
rtl/uvs_cache.sv
rtl/uv_sphere_vertex_generator.sv
tb/uv_sphere_vertex_generator_tb.sv
